// ===== rtl/buddy_block_allocator_defines.svh =====
// Assertion macros used by the allocator source.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
package bba_pkg;

  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned SIZE_W    = 21;
  localparam int unsigned ADDR_W    = 19;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [25:0] {
    S_IDLE  = 26'd1 << 0,
    S_AWANT = 26'd1 << 1,
    S_ASRCH = 26'd1 << 2,
    S_ASPL  = 26'd1 << 3,
    S_ASP1  = 26'd1 << 4,
    S_ASP2  = 26'd1 << 5,
    S_ASP3  = 26'd1 << 6,
    S_ASP4  = 26'd1 << 7,
    S_AFIN  = 26'd1 << 8,
    S_F0    = 26'd1 << 9,
    S_F1    = 26'd1 << 10,
    S_F2    = 26'd1 << 11,
    S_F3    = 26'd1 << 12,
    S_F4    = 26'd1 << 13,
    S_F5    = 26'd1 << 14,
    S_F6    = 26'd1 << 15,
    S_UF0   = 26'd1 << 16,
    S_UF1   = 26'd1 << 17,
    S_P0    = 26'd1 << 18,
    S_P1    = 26'd1 << 19,
    S_UA0   = 26'd1 << 20,
    S_UA1   = 26'd1 << 21,
    S_UA2   = 26'd1 << 22,
    S_MRD   = 26'd1 << 23,
    S_MWR   = 26'd1 << 24,
    S_FDONE = 26'd1 << 25
  } state_t;

endpackage

// ===== rtl/bba_ram.sv =====
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// Header updates are read-modify-writes on the header memory, through the states S_MRD
// and S_MWR.
// Throughput: one command at a time; start is taken only while busy is low.
// Reset (synchronous, rst high): the whole heap becomes one free block of top order.
// The result beat is a one-cycle strobe on done; the receiver cannot stall it.
`include "buddy_block_allocator_defines.svh"

module buddy_block_allocator #(
  parameter int unsigned HEAP_ORDER_LOG = 19,
  parameter int unsigned MIN_ORDER_LOG  = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [19:0] alloc_size,
  input  logic [18:0] free_address,
  output logic        done,
  output logic [18:0] data_address,
  output logic        failed
);

  // Block numbers, order field and header word layout.  A header holds the
  // used flag, the order and the previous and next links of its free list.
  localparam int unsigned BB   = HEAP_ORDER_LOG - MIN_ORDER_LOG;
  localparam int unsigned NBLK = 1 << BB;
  localparam int unsigned OW   = $clog2(HEAP_ORDER_LOG + 2);
  localparam int unsigned NH   = 1 << OW;
  localparam int unsigned HW   = 1 + OW + 2 * BB;
  localparam int unsigned CW   = (HEAP_ORDER_LOG + 1 > bba_pkg::SIZE_W) ?
                                 HEAP_ORDER_LOG + 1 : bba_pkg::SIZE_W;
  localparam logic [OW-1:0] TOP  = OW'(HEAP_ORDER_LOG);
  localparam logic [OW-1:0] MINO = OW'(MIN_ORDER_LOG);

  typedef struct packed {
    logic [BB-1:0] addr;
    logic          wen;
    logic          su;
    logic          u;
    logic          so;
    logic [OW-1:0] o;
    logic          sp;
    logic [BB-1:0] p;
    logic          sn;
    logic [BB-1:0] n;
  } op_t;

  function automatic op_t mkop(input logic [BB-1:0] a, input logic w,
                               input logic su, input logic u,
                               input logic so, input logic [OW-1:0] o,
                               input logic sp, input logic [BB-1:0] p,
                               input logic sn, input logic [BB-1:0] n);
    op_t r;
    r.addr = a; r.wen = w; r.su = su; r.u = u; r.so = so; r.o = o;
    r.sp = sp; r.p = p; r.sn = sn; r.n = n;
    return r;
  endfunction

  bba_pkg::state_t state, ret, mret;
  op_t             op;

  // Free list heads; entries above the top order are never set.
  logic          head_v [NH];
  logic [BB-1:0] head_b [NH];
  // Block zero reads as a free top-order block until it is first written.
  logic          hdr0_ok;

  // Command of the beat in progress.
  logic            cmd_q;

  logic [CW-1:0]   size, pw;
  logic [OW-1:0]   want, lvl, pl;
  logic [BB-1:0]   h, lo, hi, b, px, ux, p, n, nn;
  logic            hp, hn;
  logic [HW-1:0]   rd_hdr;

  logic [HW-1:0]   mem_q, cur, merged;
  logic            ram_we;
  logic [CW-1:0]   size_in;
  logic [HEAP_ORDER_LOG+18:0] fa_wide, da_wide;
  logic [HEAP_ORDER_LOG-1:0]  fa_heap;
  logic [BB-1:0]   fblk, nbuddy, hi_new, hmin;

  logic            rd_used;
  logic [OW-1:0]   rd_order;
  logic [BB-1:0]   rd_prev, rd_next;

  assign rd_used  = rd_hdr[HW-1];
  assign rd_order = rd_hdr[HW-2 -: OW];
  assign rd_prev  = rd_hdr[2*BB-1:BB];
  assign rd_next  = rd_hdr[BB-1:0];

  assign busy = (state != bba_pkg::S_IDLE);

  // Header memory: one read address, one write port, registered read.
  bba_ram #(.WIDTH(HW), .DEPTH(NBLK)) u_hdr (
    .clk   (clk),
    .we    (ram_we),
    .waddr (op.addr),
    .wdata (merged),
    .raddr (op.addr),
    .rdata (mem_q)
  );

  always_comb begin
    cur = mem_q;
    if (op.addr == '0 && !hdr0_ok) begin
      cur = {1'b0, TOP, {BB{1'b0}}, {BB{1'b0}}};
    end
    merged = cur;
    if (op.su) merged[HW-1] = op.u;
    if (op.so) merged[HW-2 -: OW] = op.o;
    if (op.sp) merged[2*BB-1:BB] = op.p;
    if (op.sn) merged[BB-1:0] = op.n;
    ram_we = (state == bba_pkg::S_MWR) && op.wen;
  end

  // Request size plus header, free address back to a block number.
  always_comb begin
    size_in = CW'(alloc_size) + CW'(bba_pkg::HDR_BYTES);
    fa_wide = {{HEAP_ORDER_LOG{1'b0}}, free_address};
    fa_heap = fa_wide[HEAP_ORDER_LOG-1:0] - HEAP_ORDER_LOG'(bba_pkg::HDR_BYTES);
    fblk    = fa_heap[HEAP_ORDER_LOG-1:MIN_ORDER_LOG];
    da_wide = {19'd0, {h, {MIN_ORDER_LOG{1'b0}}} + HEAP_ORDER_LOG'(bba_pkg::HDR_BYTES)};
    // Buddy differs in the bit of the block's own size.
    nbuddy  = (lvl >= MINO) ? (h ^ (BB'(1) << (lvl - MINO))) : h;
    hi_new  = lo + (BB'(1) << (lvl - MINO - OW'(1)));
    hmin    = (b < h) ? b : h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bba_pkg::S_IDLE;
      ret     <= bba_pkg::S_IDLE;
      mret    <= bba_pkg::S_IDLE;
      done    <= 1'b0;
      hdr0_ok <= 1'b0;
      op      <= '0;
      for (int i = 0; i < NH; i++) begin
        head_v[i] <= (i == HEAP_ORDER_LOG);
        head_b[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        bba_pkg::S_IDLE: begin
          if (start) begin
            if (cmd == bba_pkg::CMD_ALLOC) begin
              size <= size_in;
              if (size_in > (CW'(1) << HEAP_ORDER_LOG)) begin
                done         <= 1'b1;
                failed       <= 1'b1;
                data_address <= '0;
              end else begin
                pw    <= CW'(1) << MIN_ORDER_LOG;
                want  <= MINO;
                state <= bba_pkg::S_AWANT;
              end
            end else begin
              h     <= fblk;
              op    <= mkop(fblk, 1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, '0);
              mret  <= bba_pkg::S_F1;
              state <= bba_pkg::S_MRD;
            end
          end
        end
        bba_pkg::S_AWANT: begin
          if (pw < size) begin
            pw   <= pw << 1;
            want <= want + OW'(1);
          end else begin
            lvl   <= want;
            state <= bba_pkg::S_ASRCH;
          end
        end
        bba_pkg::S_ASRCH: begin
          if (lvl > TOP) begin
            done         <= 1'b1;
            failed       <= 1'b1;
            data_address <= '0;
            state        <= bba_pkg::S_IDLE;
          end else if (head_v[lvl]) begin
            state <= bba_pkg::S_ASPL;
          end else begin
            lvl <= lvl + OW'(1);
          end
        end
        bba_pkg::S_ASPL: begin
          h     <= head_b[lvl];
          lo    <= head_b[lvl];
          ret   <= (lvl > want) ? bba_pkg::S_ASP1 : bba_pkg::S_AFIN;
          state <= bba_pkg::S_UF0;
        end
        bba_pkg::S_ASP1: begin
          lvl   <= lvl - OW'(1);
          hi    <= hi_new;
          op    <= mkop(lo, 1'b1, 1'b0, 1'b0, 1'b1, lvl - OW'(1), 1'b0, '0, 1'b0, '0);
          mret  <= bba_pkg::S_ASP2;
          state <= bba_pkg::S_MRD;
        end
        bba_pkg::S_ASP2: begin
          op    <= mkop(hi, 1'b1, 1'b1, 1'b0, 1'b1, lvl, 1'b1, hi, 1'b1, hi);
          mret  <= bba_pkg::S_ASP3;
          state <= bba_pkg::S_MRD;
        end
        bba_pkg::S_ASP3: begin
          px    <= lo;
          pl    <= lvl;
          ret   <= bba_pkg::S_ASP4;
          state <= bba_pkg::S_P0;
        end
        bba_pkg::S_ASP4: begin
          px    <= hi;
          pl    <= lvl;
          ret   <= bba_pkg::S_ASPL;
          state <= bba_pkg::S_P0;
        end
        bba_pkg::S_AFIN: begin
          op    <= mkop(h, 1'b1, 1'b1, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, '0);
          mret  <= bba_pkg::S_FDONE;
          state <= bba_pkg::S_MRD;
        end
        bba_pkg::S_F1: begin
          px    <= h;
          pl    <= rd_order;
          lvl   <= rd_order;
          ret   <= bba_pkg::S_F2;
          state <= bba_pkg::S_P0;
        end
        bba_pkg::S_F2: begin
          if (lvl < TOP) begin
            b     <= nbuddy;
            op    <= mkop(nbuddy, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, '0);
            mret  <= bba_pkg::S_F3;
            state <= bba_pkg::S_MRD;
          end else begin
            h     <= '0;
            state <= bba_pkg::S_FDONE;
          end
        end
        bba_pkg::S_F3: begin
          if (rd_used || rd_order != lvl) begin
            h     <= '0;
            state <= bba_pkg::S_FDONE;
          end else begin
            ux    <= h;
            ret   <= bba_pkg::S_F4;
            state <= bba_pkg::S_UA0;
          end
        end
        bba_pkg::S_F4: begin
          ux    <= b;
          ret   <= bba_pkg::S_F5;
          state <= bba_pkg::S_UA0;
        end
        bba_pkg::S_F5: begin
          h     <= hmin;
          lvl   <= lvl + OW'(1);
          op    <= mkop(hmin, 1'b1, 1'b0, 1'b0, 1'b1, lvl + OW'(1), 1'b0, '0, 1'b0, '0);
          mret  <= bba_pkg::S_F6;
          state <= bba_pkg::S_MRD;
        end
        bba_pkg::S_F6: begin
          px    <= h;
          pl    <= lvl;
          ret   <= bba_pkg::S_F2;
          state <= bba_pkg::S_P0;
        end
        // Unlink the front block of list lvl.
        bba_pkg::S_UF0: begin
          op    <= mkop(head_b[lvl], 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, '0);
          mret  <= bba_pkg::S_UF1;
          state <= bba_pkg::S_MRD;
        end
        bba_pkg::S_UF1: begin
          if (rd_next != op.addr) begin
            head_b[lvl] <= rd_next;
            op    <= mkop(rd_next, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b1, rd_next, 1'b0, '0);
            mret  <= ret;
            state <= bba_pkg::S_MRD;
          end else begin
            head_v[lvl] <= 1'b0;
            head_b[lvl] <= '0;
            state       <= ret;
          end
        end
        // Push block px onto the front of list pl.
        bba_pkg::S_P0: begin
          if (pl <= TOP && head_v[pl]) begin
            nn    <= head_b[pl];
            op    <= mkop(px, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b1, px, 1'b1, head_b[pl]);
            mret  <= bba_pkg::S_P1;
          end else begin
            op    <= mkop(px, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b1, px, 1'b1, px);
            mret  <= ret;
          end
          if (pl <= TOP) begin
            head_v[pl] <= 1'b1;
            head_b[pl] <= px;
          end
          state <= bba_pkg::S_MRD;
        end
        bba_pkg::S_P1: begin
          op    <= mkop(nn, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b1, px, 1'b0, '0);
          mret  <= ret;
          state <= bba_pkg::S_MRD;
        end
        // Unlink block ux from wherever it sits in its list.
        bba_pkg::S_UA0: begin
          op    <= mkop(ux, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, '0);
          mret  <= bba_pkg::S_UA1;
          state <= bba_pkg::S_MRD;
        end
        bba_pkg::S_UA1: begin
          p  <= rd_prev;
          n  <= rd_next;
          hp <= (rd_prev != ux);
          hn <= (rd_next != ux);
          if (rd_order <= TOP && head_v[rd_order] && head_b[rd_order] == ux) begin
            if (rd_next != ux) begin
              head_b[rd_order] <= rd_next;
            end else begin
              head_v[rd_order] <= 1'b0;
              head_b[rd_order] <= '0;
            end
          end
          if (rd_prev != ux) begin
            op    <= mkop(rd_prev, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b1,
                          (rd_next != ux) ? rd_next : rd_prev);
            mret  <= bba_pkg::S_UA2;
            state <= bba_pkg::S_MRD;
          end else begin
            state <= bba_pkg::S_UA2;
          end
        end
        bba_pkg::S_UA2: begin
          if (hn) begin
            op    <= mkop(n, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b1, hp ? p : n, 1'b0, '0);
            mret  <= ret;
            state <= bba_pkg::S_MRD;
          end else begin
            state <= ret;
          end
        end
        bba_pkg::S_MRD: begin
          state <= bba_pkg::S_MWR;
        end
        bba_pkg::S_MWR: begin
          rd_hdr <= cur;
          if (op.wen && op.addr == '0) begin
            hdr0_ok <= 1'b1;
          end
          state <= mret;
        end
        bba_pkg::S_FDONE: begin
          // Allocations report the data offset; frees land here with h cleared
          // and report zero.
          done         <= 1'b1;
          failed       <= 1'b0;
          data_address <= (cmd_q == bba_pkg::CMD_ALLOC) ? da_wide[18:0] : '0;
          state        <= bba_pkg::S_IDLE;
        end
        default: begin
          state <= bba_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  `BBA_ASSERT_SAME(a_done_idle, done, !busy, "result beat while still busy")
  `BBA_ASSERT_SAME(a_fail_zero, done && failed, data_address == '0, "failure with address")
  `BBA_ASSERT_NEXT(a_start_busy, start && !busy && !(cmd == bba_pkg::CMD_ALLOC &&
                   size_in > (CW'(1) << HEAP_ORDER_LOG)), busy, "command not taken")
  `BBA_ASSERT_SAME(a_we_busy, ram_we, busy, "header write while idle")

endmodule
